FILE: hw/rtl/gha_pkg.sv
// ----------------------------------------------------------------------------
// gha_pkg
// Request and status codes and field types shared by the handle allocator.
// ----------------------------------------------------------------------------
package gha_pkg;

  // Fixed field widths of the item ports
  localparam int REQ_W    = 3;
  localparam int ST_W     = 3;
  localparam int IN_ID_W  = 8;
  localparam int IN_VER_W = 16;
  localparam int IN_SIG_W = 32;
  localparam int OUT_ID_W = 6;
  localparam int OUT_VER_W = 16;
  localparam int OUT_MSK_W = 32;

  typedef logic [REQ_W-1:0]     req_t;
  typedef logic [ST_W-1:0]      status_t;
  typedef logic [IN_ID_W-1:0]   in_id_t;
  typedef logic [IN_VER_W-1:0]  in_ver_t;
  typedef logic [IN_SIG_W-1:0]  in_sig_t;
  typedef logic [OUT_ID_W-1:0]  out_id_t;
  typedef logic [OUT_VER_W-1:0] out_ver_t;
  typedef logic [OUT_MSK_W-1:0] out_msk_t;

  // Request codes
  localparam req_t REQ_CREATE      = 3'd0;
  localparam req_t REQ_DESTROY     = 3'd1;
  localparam req_t REQ_SET_MASK    = 3'd2;
  localparam req_t REQ_GET_MASK    = 3'd3;
  localparam req_t REQ_QUERY       = 3'd4;
  localparam req_t REQ_DESTROY_ALL = 3'd5;

  // Status codes
  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_NO_FREE   = 3'd1;
  localparam status_t ST_INVALID   = 3'd2;
  localparam status_t ST_NOT_ALIVE = 3'd3;
  localparam status_t ST_NO_MATCH  = 3'd4;

endpackage

FILE: hw/rtl/generational_handle_allocator_core.sv
// ----------------------------------------------------------------------------
// generational_handle_allocator_core
// Hands out id+version handles from a free-id FIFO, tracks alive bits,
// versions and capability masks, answers queries and destroy-all walks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one request item per handshake, taken when
//   in_valid is high and in_stall is low. in_stall is low only while the
//   block is idle, so one request is worked on at a time.
//   Result channel (out_*): result items through an output register;
//   out_last marks the final result of a request. A query gives one result
//   per live matching entry (ascending id), or one no-match result.
//   Steps: destroy, set mask and get mask read the entry memory, then
//   modify/write back; create first takes the id out of the free-id FIFO
//   memory and then reads the entry of that id. Query and destroy-all walk
//   ids 0..MAX_ENTITIES-1: a dead entry is skipped, a live entry is read
//   from the entry memory and then evaluated; after the walk comes the
//   closing result. Both memories are read through registers. Unknown
//   request types are dropped without a result.
//   Reset: free FIFO holds ids in order, all entries dead, version and mask
//   zero; per-entry written bits stand in for clearing the memories, so the
//   block is ready in the cycle after reset.
//   Stall: a held result keeps a query walk or the final step waiting; no result
//   is ever dropped or repeated.
// ----------------------------------------------------------------------------
module generational_handle_allocator_core #(
  parameter int MAX_ENTITIES = 64,
  parameter int MASK_BITS    = 32,
  parameter int VERSION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  gha_pkg::req_t      in_req_type,
  input  gha_pkg::in_id_t    in_entity_id,
  input  gha_pkg::in_ver_t   in_entity_version,
  input  gha_pkg::in_sig_t   in_signature,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output gha_pkg::status_t   out_status,
  output gha_pkg::out_id_t   out_id,
  output gha_pkg::out_ver_t  out_version,
  output gha_pkg::out_msk_t  out_mask,
  output logic               out_last
);
  import gha_pkg::*;

  localparam int IW  = $clog2(MAX_ENTITIES);
  localparam int CW  = $clog2(MAX_ENTITIES + 1);
  localparam int VW  = VERSION_BITS;
  // request mask is only 32 bits wide, so at most that many mask bits are stored
  localparam int SW  = (MASK_BITS < IN_SIG_W) ? MASK_BITS : IN_SIG_W;
  localparam int VIW = (VERSION_BITS < IN_VER_W) ? VERSION_BITS : IN_VER_W;
  localparam int EW  = VW + SW;
  localparam logic [IW-1:0]      LAST_ID  = IW'(MAX_ENTITIES - 1);
  localparam logic [CW-1:0]      FULL_CNT = CW'(MAX_ENTITIES);
  localparam logic [IN_ID_W-1:0] ID_LIMIT = IN_ID_W'(MAX_ENTITIES);

  // control states
  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a request
  localparam logic [2:0] S_CRT  = 3'd1;  // create: read entry of popped id
  localparam logic [2:0] S_EXE  = 3'd2;  // single-entry modify/write-back
  localparam logic [2:0] S_WRD  = 3'd3;  // walk: issue read of live entry
  localparam logic [2:0] S_WEX  = 3'd4;  // walk: evaluate entry
  localparam logic [2:0] S_WEND = 3'd5;  // walk: closing result

  logic [2:0]          state_r, state_nxt;
  logic [IW-1:0]       cur_r, cur_nxt;          // walk index / created id
  logic [IW-1:0]       head_r, head_nxt;
  logic [IW-1:0]       tail_r, tail_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [MAX_ENTITIES-1:0] alive_r, alive_nxt;

  // held query match, emitted once the next match or the end is known
  logic                pend_vld_r, pend_vld_nxt;
  logic [IW-1:0]       pend_id_r, pend_id_nxt;
  logic [VW-1:0]       pend_ver_r, pend_ver_nxt;

  // captured request
  req_t                item_req_r;
  logic                item_inr_r;
  logic [IW-1:0]       item_idx_r;
  in_ver_t             item_ver_r;
  in_sig_t             item_sig_r;

  // entry memory: {version, mask}; written bits stand for reset-to-zero
  logic [EW-1:0]       ent_mem [MAX_ENTITIES];
  logic [MAX_ENTITIES-1:0] ent_vld_r;
  logic [EW-1:0]       ent_rd_r;
  logic                ent_rdv_r;
  logic                ent_re, ent_we;
  logic [IW-1:0]       ent_raddr, ent_waddr;
  logic [EW-1:0]       ent_wdata;

  // free-id FIFO memory; an unwritten slot holds its own index
  logic [IW-1:0]       fid_mem [MAX_ENTITIES];
  logic [MAX_ENTITIES-1:0] fid_vld_r;
  logic [IW-1:0]       fid_rd_r;
  logic                fid_rdv_r;
  logic                fid_we;
  logic [IW-1:0]       fid_wdata;

  // output register
  logic                out_valid_r;
  status_t             out_status_r;
  out_id_t             out_id_r;
  out_ver_t            out_version_r;
  out_msk_t            out_mask_r;
  logic                out_last_r;

  logic                in_accept, in_id_ok, out_free;
  logic [VW-1:0]       ent_ver, ver_cmp;
  logic [SW-1:0]       ent_msk, sig_cut;
  logic [IW-1:0]       new_id;
  status_t             hchk;
  logic                match, adv;

  logic                emit;
  status_t             o_st;
  logic [IW-1:0]       o_id;
  logic [VW-1:0]       o_ver;
  logic [SW-1:0]       o_msk;
  logic                o_last;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign in_id_ok  = (in_entity_id < ID_LIMIT);
  assign out_free  = !out_valid_r || !out_stall;

  assign ent_ver = ent_rdv_r ? ent_rd_r[EW-1:SW] : '0;
  assign ent_msk = ent_rdv_r ? ent_rd_r[SW-1:0]  : '0;
  assign sig_cut = item_sig_r[SW-1:0];
  assign new_id  = fid_rdv_r ? fid_rd_r : head_r;
  assign match   = ((ent_msk & sig_cut) == sig_cut);

  always_comb begin
    ver_cmp = '0;
    ver_cmp[VIW-1:0] = item_ver_r[VIW-1:0];
  end

  // handle check: range, then alive and version
  always_comb begin
    if (!item_inr_r) begin
      hchk = ST_INVALID;
    end else if (!alive_r[item_idx_r] || (ent_ver != ver_cmp)) begin
      hchk = ST_NOT_ALIVE;
    end else begin
      hchk = ST_OK;
    end
  end

  // main control
  always_comb begin
    state_nxt    = state_r;
    cur_nxt      = cur_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    cnt_nxt      = cnt_r;
    alive_nxt    = alive_r;
    pend_vld_nxt = pend_vld_r;
    pend_id_nxt  = pend_id_r;
    pend_ver_nxt = pend_ver_r;
    ent_re       = 1'b0;
    ent_raddr    = cur_r;
    ent_we       = 1'b0;
    ent_waddr    = cur_r;
    ent_wdata    = '0;
    fid_we       = 1'b0;
    fid_wdata    = cur_r;
    emit         = 1'b0;
    o_st         = ST_OK;
    o_id         = '0;
    o_ver        = '0;
    o_msk        = '0;
    o_last       = 1'b1;
    adv          = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          ent_re    = 1'b1;
          ent_raddr = in_id_ok ? in_entity_id[IW-1:0] : '0;
          case (in_req_type) inside
            REQ_CREATE: state_nxt = S_CRT;
            REQ_DESTROY, REQ_SET_MASK, REQ_GET_MASK: state_nxt = S_EXE;
            REQ_QUERY, REQ_DESTROY_ALL: begin
              state_nxt    = S_WRD;
              cur_nxt      = '0;
              pend_vld_nxt = 1'b0;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      S_CRT: begin
        state_nxt = S_EXE;
        if (cnt_r != '0) begin
          ent_re    = 1'b1;
          ent_raddr = new_id;
          cur_nxt   = new_id;
        end
      end

      S_EXE: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
          ent_waddr = item_idx_r;
          case (item_req_r)
            REQ_CREATE: begin
              if (cnt_r == '0) begin
                o_st = ST_NO_FREE;
              end else begin
                o_id             = cur_r;
                o_ver            = ent_ver;
                alive_nxt[cur_r] = 1'b1;
                head_nxt         = (head_r == LAST_ID) ? '0 : head_r + 1'b1;
                cnt_nxt          = cnt_r - 1'b1;
              end
            end
            REQ_DESTROY: begin
              o_st = hchk;
              if (hchk == ST_OK) begin
                ent_we    = 1'b1;
                ent_wdata = {ent_ver + 1'b1, {SW{1'b0}}};
                alive_nxt[item_idx_r] = 1'b0;
                if (cnt_r < FULL_CNT) begin
                  fid_we    = 1'b1;
                  fid_wdata = item_idx_r;
                  tail_nxt  = (tail_r == LAST_ID) ? '0 : tail_r + 1'b1;
                  cnt_nxt   = cnt_r + 1'b1;
                end
              end
            end
            REQ_SET_MASK: begin
              o_st = hchk;
              if (hchk == ST_OK) begin
                ent_we    = 1'b1;
                ent_wdata = {ent_ver, sig_cut};
              end
            end
            REQ_GET_MASK: begin
              if (!item_inr_r) begin
                o_st = ST_INVALID;
              end else begin
                o_msk = ent_msk;
              end
            end
            default: o_st = ST_OK;
          endcase
        end
      end

      S_WRD: begin
        if (alive_r[cur_r]) begin
          ent_re    = 1'b1;
          ent_raddr = cur_r;
          state_nxt = S_WEX;
        end else if (cur_r == LAST_ID) begin
          state_nxt = S_WEND;
        end else begin
          cur_nxt = cur_r + 1'b1;
        end
      end

      S_WEX: begin
        adv = 1'b1;
        if (item_req_r == REQ_QUERY) begin
          if (match) begin
            if (pend_vld_r) begin
              if (out_free) begin
                // earlier match is not the last one
                emit         = 1'b1;
                o_id         = pend_id_r;
                o_ver        = pend_ver_r;
                o_last       = 1'b0;
                pend_id_nxt  = cur_r;
                pend_ver_nxt = ent_ver;
              end else begin
                adv = 1'b0;
              end
            end else begin
              pend_vld_nxt = 1'b1;
              pend_id_nxt  = cur_r;
              pend_ver_nxt = ent_ver;
            end
          end
        end else begin
          ent_we           = 1'b1;
          ent_wdata        = {ent_ver + 1'b1, {SW{1'b0}}};
          alive_nxt[cur_r] = 1'b0;
          if (cnt_r < FULL_CNT) begin
            fid_we    = 1'b1;
            fid_wdata = cur_r;
            tail_nxt  = (tail_r == LAST_ID) ? '0 : tail_r + 1'b1;
            cnt_nxt   = cnt_r + 1'b1;
          end
        end
        if (adv) begin
          if (cur_r == LAST_ID) begin
            state_nxt = S_WEND;
          end else begin
            cur_nxt   = cur_r + 1'b1;
            state_nxt = S_WRD;
          end
        end
      end

      S_WEND: begin
        if (out_free) begin
          emit         = 1'b1;
          state_nxt    = S_IDLE;
          pend_vld_nxt = 1'b0;
          if (item_req_r == REQ_QUERY) begin
            if (pend_vld_r) begin
              o_id  = pend_id_r;
              o_ver = pend_ver_r;
            end else begin
              o_st = ST_NO_MATCH;
            end
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= FULL_CNT;
      alive_r     <= '0;
      pend_vld_r  <= 1'b0;
      ent_vld_r   <= '0;
      fid_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cur_r      <= cur_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      cnt_r      <= cnt_nxt;
      alive_r    <= alive_nxt;
      pend_vld_r <= pend_vld_nxt;
      if (ent_we) begin
        ent_vld_r[ent_waddr] <= 1'b1;
      end
      if (fid_we) begin
        fid_vld_r[tail_r] <= 1'b1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend_id_r  <= pend_id_nxt;
    pend_ver_r <= pend_ver_nxt;
    if (in_accept) begin
      item_req_r <= in_req_type;
      item_inr_r <= in_id_ok;
      item_idx_r <= in_id_ok ? in_entity_id[IW-1:0] : '0;
      item_ver_r <= in_entity_version;
      item_sig_r <= in_signature;
    end
    if (emit) begin
      out_status_r  <= o_st;
      out_id_r      <= OUT_ID_W'(o_id);
      out_version_r <= OUT_VER_W'(o_ver[VIW-1:0]);
      out_mask_r    <= OUT_MSK_W'(o_msk);
      out_last_r    <= o_last;
    end
  end

  // entry memory
  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ent_re) begin
      ent_rd_r  <= ent_mem[ent_raddr];
      ent_rdv_r <= ent_vld_r[ent_raddr];
    end
  end

  // free-id FIFO memory, read at head on every accepted request
  always_ff @(posedge clk) begin
    if (fid_we) begin
      fid_mem[tail_r] <= fid_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      fid_rd_r  <= fid_mem[head_r];
      fid_rdv_r <= fid_vld_r[head_r];
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_id      = out_id_r;
  assign out_version = out_version_r;
  assign out_mask    = out_mask_r;
  assign out_last    = out_last_r;

  // every id is either alive or waiting in the free FIFO
  a_id_balance: assert property (@(posedge clk) disable iff (!rst_n)
    ($countones(alive_r) + int'(cnt_r)) == MAX_ENTITIES)
    else $error("alive count plus free count differs from capacity");

  // a held query match only exists inside a walk
  a_pend_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    pend_vld_r |-> (state_r == S_WRD || state_r == S_WEX || state_r == S_WEND))
    else $error("pending match outside a walk");

  // a new result is only loaded from a result-producing state
  a_emit_state: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (state_r == S_EXE || state_r == S_WEX || state_r == S_WEND))
    else $error("result produced from wrong state");

  // never overwrite a result that is still held
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !emit)
    else $error("held result overwritten");

endmodule
